FILE: hw/rtl/atcd_pkg.sv
// Shared definitions for the ARMv4T instruction class pre-decoder:
// field widths, class pattern tables, condition codes and the result type.
// No dependencies.
`default_nettype none

package atcd_pkg;

    localparam int WORD_W   = 32;
    localparam int HALF_W   = 16;
    localparam int FLAGS_W  = 4;
    localparam int COND_W   = 4;
    localparam int CLASS_W  = 5;

    localparam int THUMB_CLASS_COUNT = 19;
    localparam int ARM_CLASS_COUNT   = 13;

    // Flag bit positions within the NZCV field
    localparam int FLAG_N = 3;
    localparam int FLAG_Z = 2;
    localparam int FLAG_C = 1;
    localparam int FLAG_V = 0;

    // Thumb class patterns in priority order: masked halfword must equal value
    localparam logic [HALF_W-1:0] THUMB_MASK [THUMB_CLASS_COUNT] = '{
        16'hFF00, 16'hF800, 16'hF000, 16'hF000, 16'hF000,
        16'hFF00, 16'hF600, 16'hF000, 16'hF000, 16'hF000,
        16'hE000, 16'hF200, 16'hF200, 16'hF800, 16'hFC00,
        16'hFC00, 16'hE000, 16'hF800, 16'hE000
    };
    localparam logic [HALF_W-1:0] THUMB_VALUE [THUMB_CLASS_COUNT] = '{
        16'hDF00, 16'hE000, 16'hD000, 16'hC000, 16'hF000,
        16'hB000, 16'hB400, 16'h8000, 16'h9000, 16'hA000,
        16'h6000, 16'h5000, 16'h5200, 16'h4800, 16'h4400,
        16'h4000, 16'h2000, 16'h1800, 16'h0000
    };

    // ARM class patterns in priority order; condition bits are always masked off
    localparam logic [WORD_W-1:0] ARM_MASK [ARM_CLASS_COUNT] = '{
        32'h0FFF_FFF0, 32'h0E00_0000, 32'h0E00_0000, 32'h0F00_0000,
        32'h0E00_0010, 32'h0C00_0000, 32'h0F80_0FF0, 32'h0F00_00F0,
        32'h0E40_0F90, 32'h0E40_0090, 32'h0FBF_0000, 32'h0DB0_F000,
        32'h0C00_0000
    };
    localparam logic [WORD_W-1:0] ARM_VALUE [ARM_CLASS_COUNT] = '{
        32'h012F_FF10, 32'h0800_0000, 32'h0A00_0000, 32'h0F00_0000,
        32'h0600_0010, 32'h0400_0000, 32'h0100_0090, 32'h0000_0090,
        32'h0000_0090, 32'h0040_0090, 32'h010F_0000, 32'h0120_F000,
        32'h0000_0000
    };

    typedef enum logic [COND_W-1:0] {
        COND_EQ = 4'h0,
        COND_NE = 4'h1,
        COND_CS = 4'h2,
        COND_CC = 4'h3,
        COND_MI = 4'h4,
        COND_PL = 4'h5,
        COND_VS = 4'h6,
        COND_VC = 4'h7,
        COND_HI = 4'h8,
        COND_LS = 4'h9,
        COND_GE = 4'hA,
        COND_LT = 4'hB,
        COND_GT = 4'hC,
        COND_LE = 4'hD,
        COND_AL = 4'hE,
        COND_NV = 4'hF
    } cond_t;

    typedef struct packed {
        logic [CLASS_W-1:0] instruction_class;
        logic               condition_passed;
    } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/atcd_fetch_if.sv
// Valid/ready channel carrying one instruction transaction into the decoder.
// Depends on atcd_pkg for field widths.
`default_nettype none

interface atcd_fetch_if;
    logic                            valid;
    logic                            ready;
    logic [atcd_pkg::WORD_W-1:0]     instruction_word;
    logic                            thumb_mode;
    logic [atcd_pkg::FLAGS_W-1:0]    flags_nzcv;
    logic [atcd_pkg::COND_W-1:0]     exec_cond;

    modport source (
        output valid, instruction_word, thumb_mode, flags_nzcv, exec_cond,
        input  ready
    );
    modport sink (
        input  valid, instruction_word, thumb_mode, flags_nzcv, exec_cond,
        output ready
    );
endinterface

`default_nettype wire

FILE: hw/rtl/atcd_decode_if.sv
// Valid/ready channel carrying one decode result transaction out of the decoder.
// Depends on atcd_pkg for field widths.
`default_nettype none

interface atcd_decode_if;
    logic                            valid;
    logic                            ready;
    logic [atcd_pkg::CLASS_W-1:0]    instruction_class;
    logic                            condition_passed;

    modport source (
        output valid, instruction_class, condition_passed,
        input  ready
    );
    modport sink (
        input  valid, instruction_class, condition_passed,
        output ready
    );
endinterface

`default_nettype wire

FILE: hw/rtl/atcd_classify.sv
// Combinational class match and condition evaluation for one instruction.
// Depends on atcd_pkg (pattern tables, condition codes, result type).
`default_nettype none

module atcd_classify (
    input  wire logic [atcd_pkg::WORD_W-1:0]  instruction_word,
    input  wire logic                         thumb_mode,
    input  wire logic [atcd_pkg::FLAGS_W-1:0] flags_nzcv,
    input  wire logic [atcd_pkg::COND_W-1:0]  exec_cond,
    output atcd_pkg::result_t                 result
);

    logic [atcd_pkg::HALF_W-1:0]  half;
    logic [atcd_pkg::CLASS_W-1:0] thumb_class;
    logic [atcd_pkg::CLASS_W-1:0] arm_class;
    logic                         n, z, c, v;
    logic                         passed;

    assign half = instruction_word[atcd_pkg::HALF_W-1:0];

    // Walk from lowest priority upwards so the first match in table order wins
    always_comb
    begin
        thumb_class = atcd_pkg::CLASS_W'(atcd_pkg::THUMB_CLASS_COUNT);
        for (int i = atcd_pkg::THUMB_CLASS_COUNT - 1; i >= 0; i--)
        begin
            if ((half & atcd_pkg::THUMB_MASK[i]) == atcd_pkg::THUMB_VALUE[i])
            begin
                thumb_class = atcd_pkg::CLASS_W'(i);
            end
        end
    end

    always_comb
    begin
        arm_class = atcd_pkg::CLASS_W'(atcd_pkg::ARM_CLASS_COUNT);
        for (int i = atcd_pkg::ARM_CLASS_COUNT - 1; i >= 0; i--)
        begin
            if ((instruction_word & atcd_pkg::ARM_MASK[i]) == atcd_pkg::ARM_VALUE[i])
            begin
                arm_class = atcd_pkg::CLASS_W'(i);
            end
        end
    end

    assign n = flags_nzcv[atcd_pkg::FLAG_N];
    assign z = flags_nzcv[atcd_pkg::FLAG_Z];
    assign c = flags_nzcv[atcd_pkg::FLAG_C];
    assign v = flags_nzcv[atcd_pkg::FLAG_V];

    always_comb
    begin
        unique case (atcd_pkg::cond_t'(exec_cond))
            atcd_pkg::COND_EQ: passed = z;
            atcd_pkg::COND_NE: passed = !z;
            atcd_pkg::COND_CS: passed = c;
            atcd_pkg::COND_CC: passed = !c;
            atcd_pkg::COND_MI: passed = n;
            atcd_pkg::COND_PL: passed = !n;
            atcd_pkg::COND_VS: passed = v;
            atcd_pkg::COND_VC: passed = !v;
            atcd_pkg::COND_HI: passed = c && !z;
            atcd_pkg::COND_LS: passed = !c || z;
            atcd_pkg::COND_GE: passed = (n == v);
            atcd_pkg::COND_LT: passed = (n != v);
            atcd_pkg::COND_GT: passed = !z && (n == v);
            atcd_pkg::COND_LE: passed = z || (n != v);
            atcd_pkg::COND_AL: passed = 1'b1;
            default:           passed = 1'b0;
        endcase
    end

    assign result.instruction_class = thumb_mode ? thumb_class : arm_class;
    assign result.condition_passed  = passed;

endmodule

`default_nettype wire

FILE: hw/rtl/arm_thumb_instruction_class_decode.sv
// An accepted fetch transaction is registered in the input stage, then its decode in the result register.
// Throughput: one transaction per cycle; both stages advance together whenever
// the result register is empty or being drained in the same cycle.
// Reset: rst_n clears both stage valid flags; payload registers are not reset.
// Depends on atcd_pkg, atcd_fetch_if, atcd_decode_if and atcd_classify.
`default_nettype none

module arm_thumb_instruction_class_decode (
    input  wire logic      clk,
    input  wire logic      rst_n,
    atcd_fetch_if.sink     fetch,
    atcd_decode_if.source  decode
);

    // Input stage: captured transaction
    logic                            in_valid_reg;
    logic [atcd_pkg::WORD_W-1:0]     in_word_reg;
    logic                            in_thumb_reg;
    logic [atcd_pkg::FLAGS_W-1:0]    in_flags_reg;
    logic [atcd_pkg::COND_W-1:0]     in_cond_reg;

    // Result stage
    logic                            res_valid_reg;
    atcd_pkg::result_t               res_reg;
    atcd_pkg::result_t               res_next;

    logic                            res_ready;
    logic                            in_ready;

    // The result stage can take a new entry when empty or when its entry
    // leaves this cycle; the input stage likewise when it can hand on.
    assign res_ready = !res_valid_reg || decode.ready;
    assign in_ready  = !in_valid_reg || res_ready;

    assign fetch.ready = in_ready;

    // Classify the captured instruction between the two registers
    atcd_classify u_classify (
        .instruction_word (in_word_reg),
        .thumb_mode       (in_thumb_reg),
        .flags_nzcv       (in_flags_reg),
        .exec_cond        (in_cond_reg),
        .result           (res_next)
    );

    // Control: valid flags for both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= fetch.valid;
            end
            if (res_ready)
            begin
                res_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload: capture on advance, hold while stalled
    always_ff @(posedge clk)
    begin
        if (in_ready && fetch.valid)
        begin
            in_word_reg  <= fetch.instruction_word;
            in_thumb_reg <= fetch.thumb_mode;
            in_flags_reg <= fetch.flags_nzcv;
            in_cond_reg  <= fetch.exec_cond;
        end
        if (res_ready && in_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign decode.valid             = res_valid_reg;
    assign decode.instruction_class = res_reg.instruction_class;
    assign decode.condition_passed  = res_reg.condition_passed;

    // An accepted transaction always lands in the input stage
    a_capture: assert property (@(posedge clk) disable iff (!rst_n)
        fetch.valid && fetch.ready |=> in_valid_reg)
        else $error("accepted fetch transaction not captured");

    // A transaction handed on appears in the result register with its decode
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && res_ready |=> res_valid_reg && (res_reg == $past(res_next)))
        else $error("decode result lost or altered on advance");

    // An empty result stage never stalls the input side
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid_reg |-> fetch.ready)
        else $error("input stalled with empty result stage");

    // ARM words never decode beyond the ARM unimplemented class
    a_arm_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !in_thumb_reg |->
            res_next.instruction_class <= atcd_pkg::CLASS_W'(atcd_pkg::ARM_CLASS_COUNT))
        else $error("ARM class out of range");

    // The never condition must not pass
    a_never: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && (in_cond_reg == atcd_pkg::COND_NV) |-> !res_next.condition_passed)
        else $error("never condition passed");

endmodule

`default_nettype wire

FILE: dv/tb_arm_thumb_instruction_class_decode.sv
// Testbench for the ARM/Thumb instruction class pre-decoder: a directed table, then
// random fetch transactions checked against a local class and condition predictor.
// Depends on atcd_pkg, atcd_fetch_if, atcd_decode_if and the decoder RTL.
`timescale 1ns / 1ps

module tb_arm_thumb_instruction_class_decode;

    // Thumb classes in matching priority; the last member means no pattern matched
    typedef enum logic [atcd_pkg::CLASS_W-1:0] {
        TH_SWI, TH_BRANCH, TH_COND_BRANCH, TH_LDM_STM, TH_BRANCH_LINK,
        TH_SP_OFFSET, TH_PUSH_POP, TH_LDST_HALF, TH_LDST_SP, TH_LOAD_ADDR,
        TH_LDST_IMM, TH_LDST_REG, TH_LDST_SIGNED, TH_PC_LOAD, TH_HI_REG_BX,
        TH_ALU, TH_MOV_CMP_IMM, TH_ADD_SUB, TH_SHIFT, TH_UNIMPL
    } thumb_class_t;

    // ARM classes in matching priority; the last member means no pattern matched
    typedef enum logic [atcd_pkg::CLASS_W-1:0] {
        ARM_BX, ARM_BLOCK_XFER, ARM_BRANCH, ARM_SWI, ARM_UNDEF,
        ARM_SINGLE_XFER, ARM_SWAP, ARM_MULTIPLY, ARM_HALF_REG, ARM_HALF_IMM,
        ARM_MRS, ARM_MSR, ARM_DATA_PROC, ARM_UNIMPL
    } arm_class_t;

    // Class signatures: the masked word must equal the value. Entry k is class k.
    localparam logic [15:0] THUMB_PAT_MASK [int'(TH_UNIMPL)] = '{
        16'hFF00, 16'hF800, 16'hF000, 16'hF000, 16'hF000,
        16'hFF00, 16'hF600, 16'hF000, 16'hF000, 16'hF000,
        16'hE000, 16'hF200, 16'hF200, 16'hF800, 16'hFC00,
        16'hFC00, 16'hE000, 16'hF800, 16'hE000
    };
    localparam logic [15:0] THUMB_PAT_VALUE [int'(TH_UNIMPL)] = '{
        16'hDF00, 16'hE000, 16'hD000, 16'hC000, 16'hF000,
        16'hB000, 16'hB400, 16'h8000, 16'h9000, 16'hA000,
        16'h6000, 16'h5000, 16'h5200, 16'h4800, 16'h4400,
        16'h4000, 16'h2000, 16'h1800, 16'h0000
    };
    localparam logic [31:0] ARM_PAT_MASK [int'(ARM_UNIMPL)] = '{
        32'h0FFF_FFF0, 32'h0E00_0000, 32'h0E00_0000, 32'h0F00_0000,
        32'h0E00_0010, 32'h0C00_0000, 32'h0F80_0FF0, 32'h0F00_00F0,
        32'h0E40_0F90, 32'h0E40_0090, 32'h0FBF_0000, 32'h0DB0_F000,
        32'h0C00_0000
    };
    localparam logic [31:0] ARM_PAT_VALUE [int'(ARM_UNIMPL)] = '{
        32'h012F_FF10, 32'h0800_0000, 32'h0A00_0000, 32'h0F00_0000,
        32'h0600_0010, 32'h0400_0000, 32'h0100_0090, 32'h0000_0090,
        32'h0000_0090, 32'h0040_0090, 32'h010F_0000, 32'h0120_F000,
        32'h0000_0000
    };

    // One fetch transaction; 'typed' marks a row whose result is written in the table
    typedef struct packed {
        logic [31:0]                  word;
        logic                         thumb;
        logic [3:0]                   nzcv;
        atcd_pkg::cond_t              cond;
        logic                         typed;
        logic [atcd_pkg::CLASS_W-1:0] cls;
        logic                         passed;
    } stim_row_t;

    typedef struct {
        atcd_pkg::result_t res;
        logic [31:0]       word;
        logic              thumb;
    } decode_expect_t;

    localparam int DIRECTED_ROWS     = 25;
    localparam int RANDOM_ITEMS      = 1150;
    localparam int QUIET_TAIL        = 150;   // closing stretch with no idling at all
    localparam int LONG_STALL_AT     = 300;   // random item at which the sink holds off
    localparam int LONG_STALL_CYCLES = 80;
    localparam int DRAIN_CYCLES      = 10;    // extra wait for strays after the pipe empties
    localparam int WATCHDOG_LIMIT    = 1000;  // far above the long hold-off

    // Directed table: extremes, every condition code, the Thumb SWI/branch overlap,
    // ignored upper half and condition bits, and words that match no class
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{32'h0000_0000, 1'b0, 4'b0000, atcd_pkg::COND_EQ, 1'b1, ARM_DATA_PROC, 1'b0},
        '{32'hFFFF_FFFF, 1'b0, 4'b1111, atcd_pkg::COND_AL, 1'b1, ARM_SWI, 1'b1},
        '{32'h0000_0000, 1'b1, 4'b1111, atcd_pkg::COND_NV, 1'b1, TH_SHIFT, 1'b0},
        '{32'hFFFF_FFFF, 1'b1, 4'b0000, atcd_pkg::COND_NV, 1'b1, TH_BRANCH_LINK, 1'b0},
        '{32'hFFFF_DF5A, 1'b1, 4'b0010, atcd_pkg::COND_HI, 1'b1, TH_SWI, 1'b1},
        '{32'h0000_D0FF, 1'b1, 4'b0110, atcd_pkg::COND_HI, 1'b0, '0, 1'b0},
        '{32'hA5A5_DE00, 1'b1, 4'b0100, atcd_pkg::COND_LE, 1'b0, '0, 1'b0},
        '{32'h0000_B100, 1'b1, 4'b1000, atcd_pkg::COND_LE, 1'b1, TH_UNIMPL, 1'b1},
        '{32'h0000_E800, 1'b1, 4'b1001, atcd_pkg::COND_LE, 1'b1, TH_UNIMPL, 1'b0},
        '{32'hFFFF_BE00, 1'b1, 4'b0001, atcd_pkg::COND_NE, 1'b0, '0, 1'b0},
        '{32'h0C00_0000, 1'b0, 4'b0100, atcd_pkg::COND_NE, 1'b1, ARM_UNIMPL, 1'b0},
        '{32'hFE00_0000, 1'b0, 4'b0010, atcd_pkg::COND_CS, 1'b1, ARM_UNIMPL, 1'b1},
        '{32'hE12F_FF1E, 1'b0, 4'b0000, atcd_pkg::COND_CC, 1'b1, ARM_BX, 1'b1},
        '{32'h012F_FF10, 1'b0, 4'b1000, atcd_pkg::COND_MI, 1'b0, '0, 1'b0},
        '{32'hE10F_0000, 1'b0, 4'b0000, atcd_pkg::COND_PL, 1'b0, '0, 1'b0},
        '{32'hE129_F000, 1'b0, 4'b0001, atcd_pkg::COND_VS, 1'b0, '0, 1'b0},
        '{32'hE100_0090, 1'b0, 4'b0000, atcd_pkg::COND_VC, 1'b0, '0, 1'b0},
        '{32'hE000_0090, 1'b0, 4'b1001, atcd_pkg::COND_GE, 1'b0, '0, 1'b0},
        '{32'hE190_00B0, 1'b0, 4'b1000, atcd_pkg::COND_LT, 1'b0, '0, 1'b0},
        '{32'hE1D0_00B0, 1'b0, 4'b0000, atcd_pkg::COND_GT, 1'b0, '0, 1'b0},
        '{32'hE590_0000, 1'b0, 4'b0101, atcd_pkg::COND_GT, 1'b0, '0, 1'b0},
        '{32'hE600_0010, 1'b0, 4'b0011, atcd_pkg::COND_LS, 1'b0, '0, 1'b0},
        '{32'hEA00_0000, 1'b0, 4'b0100, atcd_pkg::COND_LS, 1'b0, '0, 1'b0},
        '{32'hE8BD_0000, 1'b0, 4'b1010, atcd_pkg::COND_AL, 1'b0, '0, 1'b0},
        '{32'h0000_4770, 1'b1, 4'b0000, atcd_pkg::COND_AL, 1'b0, '0, 1'b0}
    };

    logic clk;
    logic rst_n;

    atcd_fetch_if  fetch_ch ();
    atcd_decode_if decode_ch ();

    arm_thumb_instruction_class_decode DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .fetch  (fetch_ch),
        .decode (decode_ch)
    );

    decode_expect_t pending_decodes [$];
    decode_expect_t next_decode;
    decode_expect_t oldest_decode;
    stim_row_t      offered_row;        // row currently on the fetch channel
    int             mismatches         = 0;
    int             quiet_cycles       = 0;
    bit             idling_on          = 1'b1;
    bit             long_stall_request = 1'b0;

    // Work out class and condition result of one instruction. The signature tables
    // are walked from lowest priority upwards so that the first match in priority
    // order is the one left standing.
    function automatic atcd_pkg::result_t decode_instruction(input logic [31:0] word,
                                                             input logic thumb,
                                                             input logic [3:0] nzcv,
                                                             input atcd_pkg::cond_t cond);
        atcd_pkg::result_t r;
        logic              n;
        logic              z;
        logic              c;
        logic              v;
        n = nzcv[atcd_pkg::FLAG_N];
        z = nzcv[atcd_pkg::FLAG_Z];
        c = nzcv[atcd_pkg::FLAG_C];
        v = nzcv[atcd_pkg::FLAG_V];
        if (thumb)
        begin
            // Upper halfword plays no part in Thumb decoding
            r.instruction_class = TH_UNIMPL;
            for (int k = int'(TH_UNIMPL) - 1; k >= 0; k--)
            begin
                if ((word[15:0] & THUMB_PAT_MASK[k]) == THUMB_PAT_VALUE[k])
                    r.instruction_class = atcd_pkg::CLASS_W'(k);
            end
        end
        else
        begin
            // Signatures mask off bits 31:28, so the word's own condition is ignored
            r.instruction_class = ARM_UNIMPL;
            for (int k = int'(ARM_UNIMPL) - 1; k >= 0; k--)
            begin
                if ((word & ARM_PAT_MASK[k]) == ARM_PAT_VALUE[k])
                    r.instruction_class = atcd_pkg::CLASS_W'(k);
            end
        end
        case (cond)
            atcd_pkg::COND_EQ: r.condition_passed = z;
            atcd_pkg::COND_NE: r.condition_passed = !z;
            atcd_pkg::COND_CS: r.condition_passed = c;
            atcd_pkg::COND_CC: r.condition_passed = !c;
            atcd_pkg::COND_MI: r.condition_passed = n;
            atcd_pkg::COND_PL: r.condition_passed = !n;
            atcd_pkg::COND_VS: r.condition_passed = v;
            atcd_pkg::COND_VC: r.condition_passed = !v;
            atcd_pkg::COND_HI: r.condition_passed = c && !z;
            atcd_pkg::COND_LS: r.condition_passed = !c || z;
            atcd_pkg::COND_GE: r.condition_passed = (n == v);
            atcd_pkg::COND_LT: r.condition_passed = (n != v);
            atcd_pkg::COND_GT: r.condition_passed = !z && (n == v);
            atcd_pkg::COND_LE: r.condition_passed = z || (n != v);
            atcd_pkg::COND_AL: r.condition_passed = 1'b1;
            default:           r.condition_passed = 1'b0;    // never
        endcase
        return r;
    endfunction

    // Build a random fetch transaction. Four in five are shaped to a class signature
    // with random don't-care bits; the rest are raw noise, which is where words that
    // match nothing come from.
    function automatic stim_row_t random_instruction();
        stim_row_t row;
        int        k;
        row.word   = $urandom;
        row.thumb  = $urandom_range(0, 1);
        row.nzcv   = $urandom_range(0, 15);
        row.cond   = atcd_pkg::cond_t'($urandom_range(0, 15));
        row.typed  = 1'b0;
        row.cls    = '0;
        row.passed = 1'b0;
        if ($urandom_range(0, 4) != 0)
        begin
            if (row.thumb)
            begin
                k = $urandom_range(0, int'(TH_UNIMPL) - 1);
                row.word[15:0] = (row.word[15:0] & ~THUMB_PAT_MASK[k]) | THUMB_PAT_VALUE[k];
            end
            else
            begin
                k = $urandom_range(0, int'(ARM_UNIMPL) - 1);
                row.word = (row.word & ~ARM_PAT_MASK[k]) | ARM_PAT_VALUE[k];
            end
        end
        return row;
    endfunction

    // Offer one transaction and hold it until the decoder takes it. An idle burst
    // may go in front of it; valid is driven once per time step only.
    task automatic offer_instruction(input stim_row_t row);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            fetch_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        fetch_ch.valid            <= 1'b1;
        fetch_ch.instruction_word <= row.word;
        fetch_ch.thumb_mode       <= row.thumb;
        fetch_ch.flags_nzcv       <= row.nzcv;
        fetch_ch.exec_cond        <= row.cond;
        offered_row               <= row;
        do
            @(posedge clk);
        while (!(fetch_ch.valid === 1'b1 && fetch_ch.ready === 1'b1));
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Source side: reset, directed table, random stream, then drain and verdict
    initial
    begin
        rst_n                     <= 1'b0;
        fetch_ch.valid            <= 1'b0;
        fetch_ch.instruction_word <= '0;
        fetch_ch.thumb_mode       <= 1'b0;
        fetch_ch.flags_nzcv       <= '0;
        fetch_ch.exec_cond        <= '0;
        offered_row               <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            offer_instruction(DIRECTED[i]);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // Idle in stretches, with every fourth block of 64 clean, and none at the end
            idling_on = (i < RANDOM_ITEMS - QUIET_TAIL) && ((i / 64) % 4 != 3);
            // Ask the sink for its long hold-off; keep offering so the pipe backs up
            if (i == LONG_STALL_AT)
                long_stall_request = 1'b1;
            offer_instruction(random_instruction());
        end
        fetch_ch.valid <= 1'b0;

        // Wait out every outstanding result, then a few cycles for strays
        while (pending_decodes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("arm_thumb_instruction_class_decode regression: pass");
        else
            $display("arm_thumb_instruction_class_decode regression: fail");
        $finish;
    end

    // Sink side: random ready bursts, one long hold-off on request
    initial
    begin
        decode_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (long_stall_request)
            begin
                long_stall_request = 1'b0;
                decode_ch.ready <= 1'b0;
                repeat (LONG_STALL_CYCLES) @(posedge clk);
            end
            else if (idling_on && $urandom_range(0, 3) == 0)
            begin
                decode_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            else
            begin
                decode_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // Scoreboard: check the result taken at this edge against the oldest prediction
    // first, then record the prediction for any fetch taken at the same edge. All
    // channel values are read before the edge's nonblocking updates land.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (decode_ch.valid === 1'b1 && decode_ch.ready === 1'b1)
            begin
                if (pending_decodes.size() == 0)
                begin
                    $error("decode result with nothing outstanding: class %0d, passed %0b",
                           decode_ch.instruction_class, decode_ch.condition_passed);
                    mismatches++;
                end
                else
                begin
                    oldest_decode = pending_decodes.pop_front();
                    if (decode_ch.instruction_class !== oldest_decode.res.instruction_class)
                    begin
                        $error("instruction_class: expected %0d, actual %0d (word %h, thumb %b)",
                               oldest_decode.res.instruction_class,
                               decode_ch.instruction_class,
                               oldest_decode.word, oldest_decode.thumb);
                        mismatches++;
                    end
                    if (decode_ch.condition_passed !== oldest_decode.res.condition_passed)
                    begin
                        $error("condition_passed: expected %0b, actual %0b (word %h, thumb %b)",
                               oldest_decode.res.condition_passed,
                               decode_ch.condition_passed,
                               oldest_decode.word, oldest_decode.thumb);
                        mismatches++;
                    end
                end
            end

            if (fetch_ch.valid === 1'b1 && fetch_ch.ready === 1'b1)
            begin
                // Table rows with a written result use it; everything else is predicted
                if (offered_row.typed)
                begin
                    next_decode.res.instruction_class = offered_row.cls;
                    next_decode.res.condition_passed  = offered_row.passed;
                end
                else
                begin
                    next_decode.res = decode_instruction(fetch_ch.instruction_word,
                                                         fetch_ch.thumb_mode,
                                                         fetch_ch.flags_nzcv,
                                                         atcd_pkg::cond_t'(fetch_ch.exec_cond));
                end
                next_decode.word  = fetch_ch.instruction_word;
                next_decode.thumb = fetch_ch.thumb_mode;
                pending_decodes.push_back(next_decode);
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves a transaction
    always @(posedge clk)
    begin
        if ((fetch_ch.valid === 1'b1 && fetch_ch.ready === 1'b1) ||
            (decode_ch.valid === 1'b1 && decode_ch.ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("arm_thumb_instruction_class_decode regression: fail");
            $finish;
        end
    end

endmodule
